FILE: design/bhq_pkg.sv
`default_nettype none

package bhq_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_UP_CHECK,
      ST_UP_CMP,
      ST_DN_LOAD,
      ST_DN_CHECK,
      ST_DN_LEFT,
      ST_DN_RIGHT,
      ST_DN_CMP,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      RD_PARENT,
      RD_LAST,
      RD_LEFT,
      RD_RIGHT
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_ITEM,
      WR_READ,
      WR_CAND
   } wr_sel_type;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_EMPTY = 2'd2
   } err_type;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   typedef struct packed {
      logic       accept;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       pos_from_count;
      logic       pos_clear;
      logic       pos_to_parent;
      logic       pos_to_cand;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       load_item;
      logic       load_left;
      logic       load_right;
      logic       set_err;
      err_type    err;
      logic       rsp;
   } cmd_type;

   typedef struct packed {
      logic func_pop;
      logic full;
      logic empty;
      logic pos_zero;
      logic item_greater;
      logic kid_end;
      logic right_ok;
      logic right_greater;
      logic cand_greater;
   } status_type;

endpackage

`default_nettype wire

FILE: design/bhq_ctrl.sv
`default_nettype none

module bhq_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire bhq_pkg::status_type status,
   output bhq_pkg::cmd_type        cmd,
   output logic                    busy
);

   bhq_pkg::state_type state_ff;
   bhq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bhq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bhq_pkg::ST_IDLE: begin
            if (start) state_in = bhq_pkg::ST_DECODE;
         end
         bhq_pkg::ST_DECODE: begin
            if (status.func_pop) begin
               state_in = status.empty ? bhq_pkg::ST_DONE : bhq_pkg::ST_DN_LOAD;
            end else begin
               state_in = status.full ? bhq_pkg::ST_DONE : bhq_pkg::ST_UP_CHECK;
            end
         end
         bhq_pkg::ST_UP_CHECK: begin
            state_in = status.pos_zero ? bhq_pkg::ST_DONE : bhq_pkg::ST_UP_CMP;
         end
         bhq_pkg::ST_UP_CMP: begin
            state_in = status.item_greater ? bhq_pkg::ST_UP_CHECK : bhq_pkg::ST_DONE;
         end
         bhq_pkg::ST_DN_LOAD: begin
            state_in = status.empty ? bhq_pkg::ST_DONE : bhq_pkg::ST_DN_CHECK;
         end
         bhq_pkg::ST_DN_CHECK: begin
            state_in = status.kid_end ? bhq_pkg::ST_DONE : bhq_pkg::ST_DN_LEFT;
         end
         bhq_pkg::ST_DN_LEFT: begin
            state_in = status.right_ok ? bhq_pkg::ST_DN_RIGHT : bhq_pkg::ST_DN_CMP;
         end
         bhq_pkg::ST_DN_RIGHT: begin
            state_in = bhq_pkg::ST_DN_CMP;
         end
         bhq_pkg::ST_DN_CMP: begin
            state_in = status.cand_greater ? bhq_pkg::ST_DN_CHECK : bhq_pkg::ST_DONE;
         end
         bhq_pkg::ST_DONE: begin
            state_in = bhq_pkg::ST_IDLE;
         end
         default: begin
            state_in = bhq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.rd_sel = bhq_pkg::RD_PARENT;
      cmd.wr_sel = bhq_pkg::WR_ITEM;
      cmd.err    = bhq_pkg::ERR_OK;
      busy       = (state_ff != bhq_pkg::ST_IDLE);
      case (state_ff)
         bhq_pkg::ST_IDLE: begin
            cmd.accept = start;
         end
         bhq_pkg::ST_DECODE: begin
            if (status.func_pop) begin
               if (status.empty) begin
                  cmd.set_err = 1'b1;
                  cmd.err     = bhq_pkg::ERR_EMPTY;
               end else begin
                  cmd.rd_en     = 1'b1;
                  cmd.rd_sel    = bhq_pkg::RD_LAST;
                  cmd.cnt_dec   = 1'b1;
                  cmd.pos_clear = 1'b1;
               end
            end else begin
               if (status.full) begin
                  cmd.set_err = 1'b1;
                  cmd.err     = bhq_pkg::ERR_FULL;
               end else begin
                  cmd.pos_from_count = 1'b1;
                  cmd.cnt_inc        = 1'b1;
               end
            end
         end
         bhq_pkg::ST_UP_CHECK: begin
            if (status.pos_zero) begin
               cmd.wr_en = 1'b1;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = bhq_pkg::RD_PARENT;
            end
         end
         bhq_pkg::ST_UP_CMP: begin
            cmd.wr_en = 1'b1;
            if (status.item_greater) begin
               cmd.wr_sel        = bhq_pkg::WR_READ;
               cmd.pos_to_parent = 1'b1;
            end
         end
         bhq_pkg::ST_DN_LOAD: begin
            cmd.load_item = ~status.empty;
         end
         bhq_pkg::ST_DN_CHECK: begin
            if (status.kid_end) begin
               cmd.wr_en = 1'b1;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = bhq_pkg::RD_LEFT;
            end
         end
         bhq_pkg::ST_DN_LEFT: begin
            cmd.load_left = 1'b1;
            if (status.right_ok) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = bhq_pkg::RD_RIGHT;
            end
         end
         bhq_pkg::ST_DN_RIGHT: begin
            cmd.load_right = status.right_greater;
         end
         bhq_pkg::ST_DN_CMP: begin
            cmd.wr_en = 1'b1;
            if (status.cand_greater) begin
               cmd.wr_sel      = bhq_pkg::WR_CAND;
               cmd.pos_to_cand = 1'b1;
            end
         end
         bhq_pkg::ST_DONE: begin
            cmd.rsp = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: design/bhq_datapath.sv
`default_nettype none

module bhq_datapath #(
   parameter int CAPACITY = 1024
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_func,
   input  wire logic signed [31:0]  req_value,
   input  wire bhq_pkg::cmd_type    cmd,
   output bhq_pkg::status_type      status,
   output logic                     rsp_strobe,
   output logic signed [31:0]       rsp_top_value,
   output logic                     rsp_is_empty,
   output logic [10:0]              rsp_entry_count,
   output logic [1:0]               rsp_error_code
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic signed [31:0] mem [CAPACITY];

   logic [CW-1:0]      count_ff;
   logic [AW-1:0]      pos_ff;
   logic [AW-1:0]      cand_idx_ff;
   logic signed [31:0] item_ff;
   logic signed [31:0] cand_ff;
   logic signed [31:0] rd_data_ff;
   logic signed [31:0] top_ff;
   logic               func_ff;
   bhq_pkg::err_type   err_ff;
   logic               strobe_ff;
   logic signed [31:0] top_out_ff;
   logic               empty_out_ff;
   logic [10:0]        count_out_ff;
   logic [1:0]         err_out_ff;

   logic [31:0]        count_w;
   logic [31:0]        kid_w;
   logic [31:0]        right_w;
   logic [31:0]        last_w;
   logic [31:0]        parent_w;
   logic [AW-1:0]      rd_addr;
   logic signed [31:0] wr_data;

   assign count_w  = 32'(count_ff);
   assign kid_w    = 32'({pos_ff, 1'b1});
   assign right_w  = kid_w + 32'd1;
   assign last_w   = count_w - 32'd1;
   assign parent_w = (32'(pos_ff) - 32'd1) >> 1;

   always_comb begin
      case (cmd.rd_sel)
         bhq_pkg::RD_PARENT: rd_addr = parent_w[AW-1:0];
         bhq_pkg::RD_LAST:   rd_addr = last_w[AW-1:0];
         bhq_pkg::RD_LEFT:   rd_addr = kid_w[AW-1:0];
         bhq_pkg::RD_RIGHT:  rd_addr = right_w[AW-1:0];
         default:            rd_addr = '0;
      endcase
   end

   always_comb begin
      case (cmd.wr_sel)
         bhq_pkg::WR_ITEM: wr_data = item_ff;
         bhq_pkg::WR_READ: wr_data = rd_data_ff;
         bhq_pkg::WR_CAND: wr_data = cand_ff;
         default:          wr_data = item_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[pos_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      status.func_pop      = (func_ff == bhq_pkg::FUNC_POP);
      status.full          = (count_w == 32'(CAPACITY));
      status.empty         = (count_ff == '0);
      status.pos_zero      = (pos_ff == '0);
      status.item_greater  = (item_ff > rd_data_ff);
      status.kid_end       = (kid_w >= count_w);
      status.right_ok      = (right_w < count_w);
      status.right_greater = (rd_data_ff > cand_ff);
      status.cand_greater  = (cand_ff > item_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.rsp;
         if (cmd.cnt_inc) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.cnt_dec) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff <= req_func;
         item_ff <= req_value;
         err_ff  <= bhq_pkg::ERR_OK;
      end
      if (cmd.set_err) begin
         err_ff <= cmd.err;
      end
      if (cmd.load_item) begin
         item_ff <= rd_data_ff;
      end
      if (cmd.pos_from_count) begin
         pos_ff <= count_w[AW-1:0];
      end else if (cmd.pos_clear) begin
         pos_ff <= '0;
      end else if (cmd.pos_to_parent) begin
         pos_ff <= parent_w[AW-1:0];
      end else if (cmd.pos_to_cand) begin
         pos_ff <= cand_idx_ff;
      end
      if (cmd.load_left) begin
         cand_ff     <= rd_data_ff;
         cand_idx_ff <= kid_w[AW-1:0];
      end else if (cmd.load_right) begin
         cand_ff     <= rd_data_ff;
         cand_idx_ff <= right_w[AW-1:0];
      end
      if (cmd.wr_en && (pos_ff == '0)) begin
         top_ff <= wr_data;
      end
      if (cmd.rsp) begin
         top_out_ff   <= status.empty ? 32'sd0 : top_ff;
         empty_out_ff <= status.empty;
         count_out_ff <= count_w[10:0];
         err_out_ff   <= err_ff;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_top_value   = top_out_ff;
   assign rsp_is_empty    = empty_out_ff;
   assign rsp_entry_count = count_out_ff;
   assign rsp_error_code  = err_out_ff;

endmodule

`default_nettype wire

FILE: design/binary_max_heap_queue.sv
`default_nettype none

// Max-heap priority queue over a CAPACITY-entry single-port store. Raise start
// while busy is low to issue a request (req_func 0 push req_value, 1 pop the
// top); exactly one response follows, shown for a single cycle with rsp_strobe,
// and it cannot be held off, so capture it when the strobe is high. The next
// request can already be taken while the strobe is high. A push climbs the
// new value one level at a time while it is greater than its parent. A pop
// moves the last entry to the root and sinks it while the larger child (the
// left one on a tie) is greater; a pop that empties the heap walks no level.
// At most log2(CAPACITY) levels are walked, and each level costs one or two
// reads through the single registered read port of the store. A full push or
// an empty pop is answered without touching the store, with rsp_error_code
// set. rsp_top_value reads zero when the heap is empty.
module binary_max_heap_queue #(
   parameter int CAPACITY = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_func,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_strobe,
   output logic signed [31:0]      rsp_top_value,
   output logic                    rsp_is_empty,
   output logic [10:0]             rsp_entry_count,
   output logic [1:0]              rsp_error_code
);

   bhq_pkg::cmd_type    cmd;
   bhq_pkg::status_type status;

   bhq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   bhq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_func        (req_func),
      .req_value       (req_value),
      .cmd             (cmd),
      .status          (status),
      .rsp_strobe      (rsp_strobe),
      .rsp_top_value   (rsp_top_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_entry_count (rsp_entry_count),
      .rsp_error_code  (rsp_error_code)
   );

endmodule

`default_nettype wire

FILE: design/bhq_checker.sv
`default_nettype none

module bhq_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic               req_func,
   input wire logic signed [31:0] req_value,
   input wire logic               rsp_strobe,
   input wire logic signed [31:0] rsp_top_value,
   input wire logic               rsp_is_empty,
   input wire logic [10:0]        rsp_entry_count,
   input wire logic [1:0]         rsp_error_code
);

   a_accept_goes_busy: assert property (
      @(posedge clock) disable iff (reset) (start && !busy) |=> busy
   ) else $error("request accepted but busy did not rise");

   a_strobe_when_idle: assert property (
      @(posedge clock) disable iff (reset) rsp_strobe |-> !busy
   ) else $error("response strobe while still busy");

   a_empty_matches_count: assert property (
      @(posedge clock) disable iff (reset)
         rsp_strobe |-> (rsp_is_empty == (rsp_entry_count == 11'd0))
   ) else $error("empty flag disagrees with entry count");

   a_empty_top_zero: assert property (
      @(posedge clock) disable iff (reset)
         (rsp_strobe && rsp_is_empty) |-> (rsp_top_value == 32'sd0)
   ) else $error("empty heap reports nonzero top");

   a_pop_error_empty: assert property (
      @(posedge clock) disable iff (reset)
         (rsp_strobe && (rsp_error_code == bhq_pkg::ERR_EMPTY)) |-> rsp_is_empty
   ) else $error("pop-on-empty error with entries present");

endmodule

bind binary_max_heap_queue bhq_checker u_bhq_checker (.*);

`default_nettype wire
